@@ sv/pidt_pkg.sv @@
package pidt_pkg;

    localparam int PID_W = 16;

    typedef enum logic [2:0] {
        OP_ALLOC   = 3'd0,
        OP_UNALLOC = 3'd1,
        OP_DETACH  = 3'd2,
        OP_EXIT    = 3'd3,
        OP_JOIN    = 3'd4,
        OP_WAIT    = 3'd5
    } t_op;

    localparam logic [2:0] RC_OK        = 3'd0;
    localparam logic [2:0] RC_FULL      = 3'd1;
    localparam logic [2:0] RC_INVALID   = 3'd2;
    localparam logic [2:0] RC_NOSUCH    = 3'd3;
    localparam logic [2:0] RC_DEADLOCK  = 3'd4;
    localparam logic [2:0] RC_NOTCHILD  = 3'd5;
    localparam logic [2:0] RC_NOTEXITED = 3'd6;

    typedef struct packed {
        logic [2:0]         operation;
        logic [14:0]        caller_id;
        logic [14:0]        target_id;
        logic signed [31:0] exit_status;
        logic               detach_children;
        logic               no_hang;
    } t_in;

    typedef struct packed {
        logic [2:0]         result_code;
        logic [14:0]        new_id;
        logic signed [31:0] status_out;
        logic               status_valid;
    } t_out;

    typedef struct packed {
        logic               valid;
        logic               exited;
        logic [PID_W-1:0]   pid;
        logic [14:0]        parent;
        logic signed [31:0] status;
    } t_entry;

endpackage

@@ sv/process_id_table_core.sv @@
// Process id table. Every command first reduces its ids to slot numbers. Lookup commands
// then read the target and caller slots and evaluate, alloc probes candidate ids, and exit reads,
// checks and writes back the caller, scanning every slot first when children are detached; a done
// state follows, and the result strobe is high in the cycle after it. An alloc that finds nothing
// probes 2*SLOTS candidate ids; one command is in flight at a time. After reset a clearing pass
// writes every slot with busy high. The receiver cannot stall results.
module process_id_table_core import pidt_pkg::*; #(
    parameter int SLOTS   = 128,
    parameter int ID_LOW  = 2,
    parameter int ID_HIGH = 32767,
    parameter int BOOT_ID = 1
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_in  i_cmd,
    output logic busy,
    output logic o_strobe,
    output t_out o_result
);
    localparam int SW = $clog2(SLOTS);
    localparam int UW = $clog2(SLOTS + 1);
    localparam int NW = $clog2(2 * SLOTS + 1);
    localparam logic [SW-1:0]    LOW_SLOT  = SW'(ID_LOW % SLOTS);
    localparam logic [SW-1:0]    BOOT_SLOT = SW'(BOOT_ID % SLOTS);
    localparam logic [SW-1:0]    LAST_SLOT = SW'(SLOTS - 1);
    localparam logic [PID_W-1:0] ID_LOW_V  = PID_W'(ID_LOW);
    localparam logic [PID_W-1:0] ID_HIGH_V = PID_W'(ID_HIGH);
    localparam logic [PID_W-1:0] BOOT_V    = PID_W'(BOOT_ID);

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_MOD, S_PROBE, S_RT, S_RC, S_EVAL,
        S_XRD, S_XCHK, S_SCAN, S_XRD2, S_XFIN, S_DONE
    } t_state;

    // The slot memory: one write and one registered read per cycle.
    t_entry r_mem [SLOTS];
    t_entry r_rdata;
    logic [SW-1:0] rd_addr;
    logic          we;
    logic [SW-1:0] waddr;
    t_entry        wdata;

    t_state           r_state, n_state;
    t_in              r_in, n_in;
    t_out             r_res, n_res;
    logic             r_strobe, n_strobe;
    t_entry           r_t, n_t;
    logic [SW-1:0]    r_tslot, n_tslot, r_cslot, n_cslot;
    logic [SW-1:0]    r_ci, n_ci;
    logic [UW-1:0]    r_used, n_used;
    logic [PID_W-1:0] r_next, n_next;
    logic [SW-1:0]    r_next_slot, n_next_slot;
    logic [PID_W-1:0] r_pid, n_pid, r_chk_id, n_chk_id;
    logic [SW-1:0]    r_pslot, n_pslot, r_chk_slot, n_chk_slot;
    logic             r_chk_v, n_chk_v;
    logic [NW-1:0]    r_n, n_n;
    logic [UW-1:0]    r_si, n_si;
    logic [SW-1:0]    r_wi, n_wi;
    logic             r_sv, n_sv;

    logic          rem_start, t_done, c_done;
    logic [SW-1:0] t_rem, c_rem;

    pidt_rem #(.SLOTS(SLOTS)) u_rem_t (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(rem_start),
        .i_id(i_cmd.target_id), .o_rem(t_rem), .o_done(t_done)
    );
    pidt_rem #(.SLOTS(SLOTS)) u_rem_c (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(rem_start),
        .i_id(i_cmd.caller_id), .o_rem(c_rem), .o_done(c_done)
    );

    function automatic logic [PID_W-1:0] bump_id(input logic [PID_W-1:0] id);
        return (id >= ID_HIGH_V) ? ID_LOW_V : id + PID_W'(1);
    endfunction

    function automatic logic [SW-1:0] bump_slot(input logic [PID_W-1:0] id,
                                                input logic [SW-1:0] slot);
        logic [SW-1:0] s;
        if (id >= ID_HIGH_V) begin
            s = LOW_SLOT;
        end else if (slot == LAST_SLOT) begin
            s = '0;
        end else begin
            s = slot + SW'(1);
        end
        return s;
    endfunction

    // An id finds its slot's entry only if the slot is valid, holds that id and the id is not 0.
    function automatic logic found(input t_entry e, input logic [14:0] id);
        return e.valid && (e.pid == {1'b0, id}) && (id != 15'd0);
    endfunction

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        r_rdata <= r_mem[rd_addr];
    end

    always_comb begin
        logic [UW-1:0] dec;
        t_entry        e;
        t_entry        me;
        logic [2:0]    rc;

        n_state     = r_state;
        n_in        = r_in;
        n_res       = r_res;
        n_strobe    = 1'b0;
        n_t         = r_t;
        n_tslot     = r_tslot;
        n_cslot     = r_cslot;
        n_ci        = r_ci;
        n_used      = r_used;
        n_next      = r_next;
        n_next_slot = r_next_slot;
        n_pid       = r_pid;
        n_pslot     = r_pslot;
        n_chk_id    = r_chk_id;
        n_chk_slot  = r_chk_slot;
        n_chk_v     = r_chk_v;
        n_n         = r_n;
        n_si        = r_si;
        n_wi        = r_wi;
        n_sv        = r_sv;
        rem_start   = 1'b0;
        rd_addr     = r_tslot;
        we          = 1'b0;
        waddr       = r_tslot;
        wdata       = '0;
        dec         = (r_used != '0) ? r_used - UW'(1) : r_used;
        e           = r_rdata;
        me          = r_rdata;
        rc          = RC_INVALID;

        case (r_state)
            S_CLR: begin
                we    = 1'b1;
                waddr = r_ci;
                if (r_ci == BOOT_SLOT) begin
                    wdata.valid = 1'b1;
                    wdata.pid   = BOOT_V;
                end
                n_ci = r_ci + SW'(1);
                if (r_ci == LAST_SLOT) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_in      = i_cmd;
                    rem_start = 1'b1;
                    n_state   = S_MOD;
                end
            end
            S_MOD: begin
                n_tslot = t_rem;
                n_cslot = c_rem;
                if (t_done && c_done) begin
                    n_res = '0;
                    case (r_in.operation)
                        OP_ALLOC: begin
                            if (r_in.caller_id == 15'd0) begin
                                n_res.result_code = RC_INVALID;
                                n_state = S_DONE;
                            end else if (r_used >= UW'(SLOTS)) begin
                                n_res.result_code = RC_FULL;
                                n_state = S_DONE;
                            end else begin
                                n_pid   = r_next;
                                n_pslot = r_next_slot;
                                n_chk_v = 1'b0;
                                n_n     = '0;
                                n_state = S_PROBE;
                            end
                        end
                        OP_UNALLOC, OP_DETACH, OP_JOIN, OP_WAIT: n_state = S_RT;
                        OP_EXIT: n_state = S_XRD;
                        default: begin
                            n_res.result_code = RC_INVALID;
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_PROBE: begin
                // Reads run one candidate ahead of the check of the one before.
                rd_addr = r_pslot;
                if (r_n != NW'(2 * SLOTS)) begin
                    n_chk_id   = r_pid;
                    n_chk_slot = r_pslot;
                    n_chk_v    = 1'b1;
                    n_pid      = bump_id(r_pid);
                    n_pslot    = bump_slot(r_pid, r_pslot);
                    n_n        = r_n + NW'(1);
                end else begin
                    n_chk_v = 1'b0;
                end
                if (r_chk_v && !r_rdata.valid) begin
                    we           = 1'b1;
                    waddr        = r_chk_slot;
                    wdata.valid  = 1'b1;
                    wdata.pid    = r_chk_id;
                    wdata.parent = r_in.caller_id;
                    n_used       = r_used + UW'(1);
                    n_next       = bump_id(r_chk_id);
                    n_next_slot  = bump_slot(r_chk_id, r_chk_slot);
                    n_res.result_code = RC_OK;
                    n_res.new_id      = r_chk_id[14:0];
                    n_state = S_DONE;
                end else if (r_chk_v && r_n == NW'(2 * SLOTS)) begin
                    n_res.result_code = RC_FULL;
                    n_state = S_DONE;
                end
            end
            S_RT: begin
                rd_addr = r_tslot;
                n_state = S_RC;
            end
            S_RC: begin
                n_t     = r_rdata;
                rd_addr = r_cslot;
                n_state = S_EVAL;
            end
            S_EVAL: begin
                // r_t holds the target's slot and r_rdata the caller's.
                e     = r_t;
                waddr = r_tslot;
                n_state = S_DONE;
                case (r_in.operation)
                    OP_UNALLOC: begin
                        if ({1'b0, r_in.target_id} < ID_LOW_V ||
                            {1'b0, r_in.target_id} > ID_HIGH_V) begin
                            rc = RC_INVALID;
                        end else if (!found(e, r_in.target_id)) begin
                            rc = RC_NOSUCH;
                        end else if (e.exited) begin
                            rc = RC_INVALID;
                        end else if (e.parent != r_in.caller_id) begin
                            rc = RC_NOTCHILD;
                        end else begin
                            we     = 1'b1;
                            n_used = dec;
                            rc     = RC_OK;
                        end
                    end
                    OP_DETACH: begin
                        if (r_in.target_id == 15'd0 || {1'b0, r_in.target_id} == BOOT_V) begin
                            rc = RC_INVALID;
                        end else if (!found(e, r_in.target_id)) begin
                            rc = RC_NOSUCH;
                        end else if (e.parent == 15'd0) begin
                            rc = RC_INVALID;
                        end else if (!found(me, r_in.caller_id)) begin
                            rc = RC_NOSUCH;
                        end else if (e.parent != r_in.caller_id) begin
                            rc = RC_INVALID;
                        end else begin
                            we = 1'b1;
                            if (!e.exited) begin
                                wdata        = e;
                                wdata.parent = '0;
                            end else begin
                                n_used = dec;
                            end
                            rc = RC_OK;
                        end
                    end
                    default: begin
                        // Join, and wait after its own parent check.
                        if (r_in.operation == OP_WAIT && !found(e, r_in.target_id)) begin
                            rc = RC_NOSUCH;
                        end else if (r_in.operation == OP_WAIT &&
                                     e.parent != r_in.caller_id) begin
                            rc = RC_NOTCHILD;
                        end else if (r_in.target_id == 15'd0 ||
                                     {1'b0, r_in.target_id} == BOOT_V) begin
                            rc = RC_INVALID;
                        end else if (!found(e, r_in.target_id)) begin
                            rc = RC_NOSUCH;
                        end else if (e.parent == 15'd0) begin
                            rc = RC_INVALID;
                        end else if (!found(me, r_in.caller_id)) begin
                            rc = RC_NOSUCH;
                        end else if (r_in.target_id == r_in.caller_id) begin
                            rc = RC_DEADLOCK;
                        end else if (r_in.no_hang) begin
                            rc = RC_OK;
                        end else if (!e.exited) begin
                            rc = RC_NOTEXITED;
                        end else begin
                            rc = RC_OK;
                            n_res.new_id       = r_in.target_id;
                            n_res.status_out   = e.status;
                            n_res.status_valid = 1'b1;
                        end
                    end
                endcase
                n_res.result_code = rc;
            end
            S_XRD: begin
                rd_addr = r_cslot;
                n_state = S_XCHK;
            end
            S_XCHK: begin
                if (!found(me, r_in.caller_id)) begin
                    n_res.result_code = RC_NOSUCH;
                    n_state = S_DONE;
                end else if (me.exited) begin
                    n_res.result_code = RC_INVALID;
                    n_state = S_DONE;
                end else if (r_in.detach_children) begin
                    n_si    = '0;
                    n_sv    = 1'b0;
                    n_state = S_SCAN;
                end else begin
                    n_state = S_XRD2;
                end
            end
            S_SCAN: begin
                // Read slot r_si while the earlier-read slot r_wi is written back.
                rd_addr = r_si[SW-1:0];
                if (r_si != UW'(SLOTS)) begin
                    n_wi = r_si[SW-1:0];
                    n_si = r_si + UW'(1);
                    n_sv = 1'b1;
                end else begin
                    n_sv = 1'b0;
                    if (!r_sv) begin
                        n_state = S_XRD2;
                    end
                end
                if (r_sv && e.valid && e.parent == r_in.caller_id && e.pid != BOOT_V) begin
                    we    = 1'b1;
                    waddr = r_wi;
                    if (!e.exited) begin
                        wdata        = e;
                        wdata.parent = '0;
                    end else begin
                        n_used = dec;
                    end
                end
            end
            S_XRD2: begin
                rd_addr = r_cslot;
                n_state = S_XFIN;
            end
            S_XFIN: begin
                we    = 1'b1;
                waddr = r_cslot;
                if (me.parent == 15'd0) begin
                    n_used = dec;
                end else begin
                    wdata        = me;
                    wdata.exited = 1'b1;
                    wdata.status = r_in.exit_status;
                end
                n_res.result_code = RC_OK;
                n_state = S_DONE;
            end
            S_DONE: begin
                n_strobe = 1'b1;
                n_state  = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_ci        <= '0;
            r_used      <= UW'(1);
            r_next      <= ID_LOW_V;
            r_next_slot <= LOW_SLOT;
            r_strobe    <= 1'b0;
            r_chk_v     <= 1'b0;
            r_sv        <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ci        <= n_ci;
            r_used      <= n_used;
            r_next      <= n_next;
            r_next_slot <= n_next_slot;
            r_strobe    <= n_strobe;
            r_chk_v     <= n_chk_v;
            r_sv        <= n_sv;
        end
        r_in       <= n_in;
        r_res      <= n_res;
        r_t        <= n_t;
        r_tslot    <= n_tslot;
        r_cslot    <= n_cslot;
        r_pid      <= n_pid;
        r_pslot    <= n_pslot;
        r_chk_id   <= n_chk_id;
        r_chk_slot <= n_chk_slot;
        r_n        <= n_n;
        r_si       <= n_si;
        r_wi       <= n_wi;
    end

    // The result beat is a one-cycle strobe, registered from the done state.
    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_res;

`ifndef SYNTH
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= UW'(SLOTS)) else $error("used count exceeds slot count");
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("accepted beat did not raise busy");
    a_strobe_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_state == S_DONE)) else $error("stray result beat");
    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_result.result_code != 3'd7)) else $error("bad result code");
`endif
endmodule

@@ sv/pidt_rem.sv @@
module pidt_rem import pidt_pkg::*; #(
    parameter int SLOTS = 128
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [14:0]              i_id,
    output logic [$clog2(SLOTS)-1:0] o_rem,
    output logic                     o_done
);
    // Remainder by reciprocal multiplication: the quotient is taken from the product and registered
    // on start, and the remainder is then formed from it and registered.
    localparam int          SW      = $clog2(SLOTS);
    localparam int          KS      = 15 + SW;
    localparam longint      RECIP   = ((longint'(1) << KS) + longint'(SLOTS) - 1)
                                      / longint'(SLOTS);
    localparam logic [15:0] RECIP_V = 16'(RECIP);
    localparam logic [14:0] SLOTS_V = 15'(SLOTS);

    logic [14:0]   r_id;
    logic [14:0]   r_q;
    logic [SW-1:0] r_rem;
    logic          r_run;
    logic          r_done;
    logic [30:0]   n_prod;
    logic [14:0]   n_q;
    logic [14:0]   n_rem;

    always_comb begin
        n_prod = 31'(i_id) * 31'(RECIP_V);
        n_q    = 15'(n_prod >> KS);
        n_rem  = r_id - r_q * SLOTS_V;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_id  <= i_id;
                r_q   <= n_q;
            end else if (r_run) begin
                r_run  <= 1'b0;
                r_done <= 1'b1;
                r_rem  <= n_rem[SW-1:0];
            end
        end
    end

    assign o_rem  = r_rem;
    assign o_done = r_done;
endmodule
